[design/pape_pkg.sv]
package pape_pkg;

  // Table depth and the index and count widths that follow from it.
  localparam int MAX_POINTS = 64;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // Step counts of the shared multiply and divide unit.
  localparam int MUL_STEPS = 31;
  localparam int DIV_STEPS = 64;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_POS = 2'd0;
  localparam logic [1:0] CFG_START_VEL = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE = 2'd2;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_POP     = 2'd2,
    CMD_EVAL    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NEG_VEL = 3'd1,
    ST_FULL    = 3'd2,
    ST_FEW     = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] seg_accel;
    logic [30:0]        seg_duration;
    logic [30:0]        query_time;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [30:0]        time_span;
    logic [6:0]         point_count;
  } res_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] accel;
    logic [30:0]        knot_time;
  } knot_t;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AP_LD,
    S_AP_MUL1,
    S_AP_CHK,
    S_AP_MUL2,
    S_EV_LAST,
    S_EV_BS,
    S_EV_CMP,
    S_EV_LD0,
    S_EV_LD1,
    S_EV_MUL,
    S_EV_DIV,
    S_EV_PSTART,
    S_EV_PMUL,
    S_SPAN,
    S_SPAN_WAIT
  } state_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sd2147483647;
    lo_lim = -64'sd2147483648;
    if (x > hi_lim) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo_lim) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Magnitude of a 33 bit signed value.
  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

endpackage

[design/piecewise_accel_profile_engine_unit.sv]
// Trajectory engine for piecewise constant-acceleration profiles. It keeps up
// to 64 knot points (position, velocity and acceleration in signed Q16.16,
// time in unsigned Q15.16) in a table with one read and one write port and
// takes one request at a time: restart, append, pop or evaluate. Each request
// gives exactly one result, which is held in an output register until it is
// taken; no new request is accepted while it waits. An append runs two
// multiplies, and a successful evaluate up to 6 binary search probes, two
// multiplies and one divide (one multiply if its segment has zero length).
// A rejected append or evaluate runs no multiply or divide, except an append
// refused for a negative end velocity, which has to run its first multiply.
// Each multiply and divide uses the one shared add/subtract unit, which works
// one bit per cycle.
module piecewise_accel_profile_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pape_pkg::req_t    req,
  output logic              res_valid,
  input  logic              res_stall,
  output pape_pkg::res_t    res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int AW = pape_pkg::AW;
  localparam int CW = pape_pkg::CW;

  // Configuration registers.
  logic signed [31:0] start_pos;
  logic signed [31:0] start_vel;
  logic [16:0]        tol;

  // The knot table, one read port with registered data and one write port.
  pape_pkg::knot_t mem [pape_pkg::MAX_POINTS];
  pape_pkg::knot_t rdata;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  pape_pkg::knot_t mem_wd;

  // Sequencer state and working registers.
  pape_pkg::state_t   state, state_next;
  logic [CW-1:0]      count, count_next;
  logic signed [31:0] a_q, a_q_next;
  logic [30:0]        dur, dur_next;
  logic [30:0]        t_q, t_q_next;
  logic signed [31:0] s0, s0_next;
  logic signed [31:0] v0, v0_next;
  logic [30:0]        t0, t0_next;
  logic signed [31:0] v1, v1_next;
  logic signed [31:0] acc, acc_next;
  logic signed [31:0] vel, vel_next;
  logic signed [31:0] pos, pos_next;
  pape_pkg::status_t  status, status_next;
  logic [AW-1:0]      lo, lo_next;
  logic [AW-1:0]      hi, hi_next;
  logic [AW-1:0]      mid, mid_next;
  logic               sgn, sgn_next;
  logic [30:0]        dt, dt_next;
  logic [30:0]        dtt, dtt_next;
  logic               res_valid_next;
  pape_pkg::res_t     res_next;

  // Shared multiply/divide unit.
  pape_pkg::md_req_t md_req;
  logic [32:0]       md_opnd;
  logic [63:0]       md_init;
  logic              md_done;
  logic [63:0]       md_result;

  pape_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .opnd   (md_opnd),
    .init   (md_init),
    .done   (md_done),
    .result (md_result)
  );

  // Arithmetic around the shared unit. Products are formed on magnitudes,
  // so the shifts and the quotient truncate toward zero before the sign is
  // put back.
  logic               accept;
  logic [CW-1:0]      cnt_m1;
  logic signed [63:0] v0_ext;
  logic signed [63:0] s0_ext;
  logic [63:0]        prod16;
  logic [63:0]        prod17;
  logic signed [63:0] adj16;
  logic signed [63:0] adj17;
  logic signed [63:0] adjq;
  logic signed [31:0] v1_cand;
  logic signed [31:0] s_cand;
  logic signed [31:0] vel_cand;
  logic signed [31:0] s1_final;
  logic signed [33:0] tol_sum;
  logic signed [32:0] sum_v0v1;
  logic signed [32:0] sum_v0vel;
  logic signed [32:0] vdiff;
  logic [30:0]        dt_cand;
  logic [30:0]        dtt_cand;
  logic [31:0]        t1_sum;
  logic [30:0]        t1_final;
  logic [AW:0]        mid_sum;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != pape_pkg::S_IDLE) || res_valid;
  assign cnt_m1    = count - CW'(1);
  assign v0_ext    = {{32{v0[31]}}, v0};
  assign s0_ext    = {{32{s0[31]}}, s0};
  assign prod16    = {16'd0, md_result[63:16]};
  assign prod17    = {17'd0, md_result[63:17]};
  assign adj16     = sgn ? -$signed(prod16) : $signed(prod16);
  assign adj17     = sgn ? -$signed(prod17) : $signed(prod17);
  assign adjq      = sgn ? -$signed(md_result) : $signed(md_result);
  assign v1_cand   = pape_pkg::sat32(v0_ext + adj16);
  assign s_cand    = pape_pkg::sat32(s0_ext + adj17);
  assign vel_cand  = pape_pkg::sat32(v0_ext + adjq);
  assign s1_final  = (s_cand < s0) ? s0 : s_cand;
  assign tol_sum   = {{2{v1[31]}}, v1} + $signed({17'd0, tol});
  assign sum_v0v1  = {v0[31], v0} + {v1[31], v1};
  assign sum_v0vel = {v0[31], v0} + {vel[31], vel};
  assign vdiff     = {rdata.velocity[31], rdata.velocity} - {v0[31], v0};
  assign dt_cand   = rdata.knot_time - t0;
  assign dtt_cand  = t_q - t0;
  assign t1_sum    = {1'b0, t0} + {1'b0, dur};
  assign t1_final  = t1_sum[31] ? 31'h7FFFFFFF : t1_sum[30:0];
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= '0;
      start_vel <= '0;
      tol       <= 17'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pape_pkg::CFG_START_POS: start_pos <= cfg_data;
        pape_pkg::CFG_START_VEL: start_vel <= cfg_data;
        pape_pkg::CFG_TOLERANCE: tol <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pape_pkg::S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    a_q    <= a_q_next;
    dur    <= dur_next;
    t_q    <= t_q_next;
    s0     <= s0_next;
    v0     <= v0_next;
    t0     <= t0_next;
    v1     <= v1_next;
    acc    <= acc_next;
    vel    <= vel_next;
    pos    <= pos_next;
    status <= status_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    sgn    <= sgn_next;
    dt     <= dt_next;
    dtt    <= dtt_next;
    res    <= res_next;
  end

  // Sequencer: one request walks through the states below, borrowing the
  // shared unit for each multiply and divide and the table port for each
  // knot it needs. Every request ends by reading the last knot's time for
  // the span (zero with fewer than two knots) and loading the result register.
  always_comb begin
    state_next     = state;
    count_next     = count;
    a_q_next       = a_q;
    dur_next       = dur;
    t_q_next       = t_q;
    s0_next        = s0;
    v0_next        = v0;
    t0_next        = t0;
    v1_next        = v1;
    acc_next       = acc;
    vel_next       = vel;
    pos_next       = pos;
    status_next    = status;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    sgn_next       = sgn;
    dt_next        = dt;
    dtt_next       = dtt;
    res_next       = res;
    res_valid_next = res_valid && res_stall;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    md_req.start   = 1'b0;
    md_req.op      = pape_pkg::MD_MUL;
    md_opnd        = '0;
    md_init        = '0;

    unique case (state)
      pape_pkg::S_IDLE: begin
        if (accept) begin
          a_q_next    = req.seg_accel;
          dur_next    = req.seg_duration;
          t_q_next    = req.query_time;
          pos_next    = '0;
          vel_next    = '0;
          acc_next    = '0;
          status_next = pape_pkg::ST_OK;
          state_next  = pape_pkg::S_SPAN;
          rd_addr     = cnt_m1[AW-1:0];
          unique case (req.cmd)
            pape_pkg::CMD_RESTART: begin
              mem_we     = 1'b1;
              mem_wa     = '0;
              mem_wd     = '{position: start_pos, velocity: start_vel,
                             accel: '0, knot_time: '0};
              count_next = CW'(1);
            end
            pape_pkg::CMD_APPEND: begin
              if (count == '0) begin
                status_next = pape_pkg::ST_FEW;
              end else if (count >= CW'(pape_pkg::MAX_POINTS)) begin
                status_next = pape_pkg::ST_FULL;
              end else begin
                state_next = pape_pkg::S_AP_LD;
              end
            end
            pape_pkg::CMD_POP: begin
              if (count != '0) begin
                count_next = cnt_m1;
              end
            end
            pape_pkg::CMD_EVAL: begin
              if (count < CW'(2)) begin
                status_next = pape_pkg::ST_FEW;
              end else begin
                state_next = pape_pkg::S_EV_LAST;
              end
            end
          endcase
        end
      end

      pape_pkg::S_AP_LD: begin
        s0_next      = rdata.position;
        v0_next      = rdata.velocity;
        t0_next      = rdata.knot_time;
        sgn_next     = a_q[31];
        md_req.start = 1'b1;
        md_req.op    = pape_pkg::MD_MUL;
        md_opnd      = pape_pkg::mag33({a_q[31], a_q});
        md_init      = {33'd0, dur};
        state_next   = pape_pkg::S_AP_MUL1;
      end

      pape_pkg::S_AP_MUL1: begin
        if (md_done) begin
          v1_next    = v1_cand;
          state_next = pape_pkg::S_AP_CHK;
        end
      end

      pape_pkg::S_AP_CHK: begin
        if (tol_sum[33]) begin
          status_next = pape_pkg::ST_NEG_VEL;
          state_next  = pape_pkg::S_SPAN;
        end else begin
          sgn_next     = sum_v0v1[32];
          md_req.start = 1'b1;
          md_req.op    = pape_pkg::MD_MUL;
          md_opnd      = pape_pkg::mag33(sum_v0v1);
          md_init      = {33'd0, dur};
          state_next   = pape_pkg::S_AP_MUL2;
        end
      end

      pape_pkg::S_AP_MUL2: begin
        if (md_done) begin
          mem_we     = 1'b1;
          mem_wa     = count[AW-1:0];
          mem_wd     = '{position: s1_final, velocity: v1, accel: a_q,
                         knot_time: t1_final};
          count_next = count + CW'(1);
          state_next = pape_pkg::S_SPAN;
        end
      end

      pape_pkg::S_EV_LAST: begin
        if (t_q > rdata.knot_time) begin
          status_next = pape_pkg::ST_RANGE;
          state_next  = pape_pkg::S_SPAN;
        end else begin
          lo_next    = AW'(1);
          hi_next    = cnt_m1[AW-1:0];
          state_next = pape_pkg::S_EV_BS;
        end
      end

      // Binary search for the first knot at or after the query time,
      // starting from knot one so that a query at time zero uses the first
      // segment.
      pape_pkg::S_EV_BS: begin
        if (lo == hi) begin
          rd_addr    = lo - AW'(1);
          state_next = pape_pkg::S_EV_LD0;
        end else begin
          mid_next   = mid_sum[AW:1];
          rd_addr    = mid_sum[AW:1];
          state_next = pape_pkg::S_EV_CMP;
        end
      end

      pape_pkg::S_EV_CMP: begin
        if (rdata.knot_time >= t_q) begin
          hi_next = mid;
        end else begin
          lo_next = mid + AW'(1);
        end
        state_next = pape_pkg::S_EV_BS;
      end

      pape_pkg::S_EV_LD0: begin
        s0_next    = rdata.position;
        v0_next    = rdata.velocity;
        t0_next    = rdata.knot_time;
        rd_addr    = lo;
        state_next = pape_pkg::S_EV_LD1;
      end

      pape_pkg::S_EV_LD1: begin
        acc_next = rdata.accel;
        dt_next  = dt_cand;
        dtt_next = dtt_cand;
        if (dt_cand != '0) begin
          sgn_next     = vdiff[32];
          md_req.start = 1'b1;
          md_req.op    = pape_pkg::MD_MUL;
          md_opnd      = pape_pkg::mag33(vdiff);
          md_init      = {33'd0, dtt_cand};
          state_next   = pape_pkg::S_EV_MUL;
        end else begin
          vel_next   = v0;
          state_next = pape_pkg::S_EV_PSTART;
        end
      end

      pape_pkg::S_EV_MUL: begin
        if (md_done) begin
          md_req.start = 1'b1;
          md_req.op    = pape_pkg::MD_DIV;
          md_opnd      = {2'b0, dt};
          md_init      = md_result;
          state_next   = pape_pkg::S_EV_DIV;
        end
      end

      pape_pkg::S_EV_DIV: begin
        if (md_done) begin
          vel_next   = vel_cand;
          state_next = pape_pkg::S_EV_PSTART;
        end
      end

      pape_pkg::S_EV_PSTART: begin
        sgn_next     = sum_v0vel[32];
        md_req.start = 1'b1;
        md_req.op    = pape_pkg::MD_MUL;
        md_opnd      = pape_pkg::mag33(sum_v0vel);
        md_init      = {33'd0, dtt};
        state_next   = pape_pkg::S_EV_PMUL;
      end

      pape_pkg::S_EV_PMUL: begin
        if (md_done) begin
          pos_next   = s_cand;
          state_next = pape_pkg::S_SPAN;
        end
      end

      // The first knot always sits at time zero, so the span is the last
      // knot's time.
      pape_pkg::S_SPAN: begin
        if (count >= CW'(2)) begin
          rd_addr    = cnt_m1[AW-1:0];
          state_next = pape_pkg::S_SPAN_WAIT;
        end else begin
          res_next       = '{status: status, position: pos, velocity: vel,
                             acceleration: acc, time_span: '0,
                             point_count: 7'(count)};
          res_valid_next = 1'b1;
          state_next     = pape_pkg::S_IDLE;
        end
      end

      pape_pkg::S_SPAN_WAIT: begin
        res_next       = '{status: status, position: pos, velocity: vel,
                           acceleration: acc, time_span: rdata.knot_time,
                           point_count: 7'(count)};
        res_valid_next = 1'b1;
        state_next     = pape_pkg::S_IDLE;
      end

      default: begin
        state_next = pape_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/pape_muldiv.sv]
// Shared add/subtract unit run as a shift-add multiplier or a restoring divider,
// one bit per cycle.
module pape_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  pape_pkg::md_req_t req,
  input  logic [32:0]       opnd,
  input  logic [63:0]       init,
  output logic              done,
  output logic [63:0]       result
);

  logic             busy;
  pape_pkg::md_op_t op_q;
  logic [6:0]       cnt;
  logic [33:0]      part;
  logic [63:0]      work;
  logic [32:0]      opnd_q;

  logic [32:0] mul_add;
  logic [32:0] rem2;
  logic [34:0] x_op;
  logic [34:0] y_op;
  logic [34:0] sum;
  logic        last;

  assign mul_add = work[0] ? opnd_q : 33'd0;
  assign rem2    = {part[31:0], work[63]};
  assign x_op    = (op_q == pape_pkg::MD_MUL) ? {1'b0, part} : {2'b0, rem2};
  assign y_op    = (op_q == pape_pkg::MD_MUL) ? {2'b0, mul_add} : {2'b0, opnd_q};
  assign sum     = (op_q == pape_pkg::MD_MUL) ? (x_op + y_op) : (x_op + ~y_op + 35'd1);
  assign last    = (op_q == pape_pkg::MD_MUL) ? (cnt == 7'(pape_pkg::MUL_STEPS - 1))
                                              : (cnt == 7'(pape_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_q <= pape_pkg::MD_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op_q <= req.op;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      part   <= '0;
      work   <= init;
      opnd_q <= opnd;
    end else if (busy) begin
      if (op_q == pape_pkg::MD_MUL) begin
        part <= {1'b0, sum[33:1]};
        work <= {work[63:31], sum[0], work[30:1]};
      end else begin
        if (sum[34]) begin
          part <= {1'b0, rem2};
        end else begin
          part <= {1'b0, sum[32:0]};
        end
        work <= {work[62:0], ~sum[34]};
      end
    end
  end

  assign result = (op_q == pape_pkg::MD_MUL) ? {part[32:0], work[30:0]} : work;

endmodule
